@@ design/deq_pkg.sv @@
// deq_pkg: shared types and constants for the deadline event queue.
// Depends on nothing; imported by deq_cell, deadline_event_queue and the test bench.
`default_nettype none

package deq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TIME_W          = 32;
    localparam int TAG_W           = 16;
    localparam int DELAY_W         = 16;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/deq_cell.sv @@
// deq_cell: one slot of the sorted event chain (deadline and tag).
// Depends on deq_pkg; instantiated once per slot by deadline_event_queue.
`default_nettype none

module deq_cell
    import deq_pkg::*;
(
    input  wire logic      aclk,
    input  wire cell_ctl_t ctl,
    input  wire logic      occupied,     // slot index below the fill count
    input  wire logic      at_tail,      // slot index equals the fill count
    input  wire logic      left_move,    // left neighbour is shifting right
    input  wire entry_t    left_entry,
    input  wire entry_t    right_entry,
    output entry_t         entry,
    output logic           move          // this slot holds a strictly later deadline
);

    entry_t entry_reg;
    entry_t entry_next;

    assign entry = entry_reg;
    assign move  = occupied && (entry_reg.deadline > ctl.new_entry.deadline);

    always_comb begin
        entry_next = entry_reg;
        case (ctl.op)
            OP_INSERT: begin
                // take the left neighbour when it shifts, else claim the new word if this slot moves or is the tail
                if (left_move) begin
                    entry_next = left_entry;
                end else if (move || at_tail) begin
                    entry_next = ctl.new_entry;
                end
            end
            OP_POP: begin
                entry_next = right_entry;
            end
            OP_HOLD: begin
                entry_next = entry_reg;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ design/deadline_event_queue.sv @@
// deadline_event_queue: timer queue kept sorted by deadline in a chain of cells.
// The input word is registered into the held word; the chain update and the result
// word follow once the result register is free, and no new word is taken until then.
// The chain inserts or removes in a single update whatever the fill count.
// Reset (aresetn low, synchronous) clears the fill count, the stored time and
// the handshakes; slot contents are left as they are and only read once written.
`default_nettype none

module deadline_event_queue
    import deq_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_cmd,
    input  wire logic [DELAY_W-1:0] s_delay_secs,
    input  wire logic [TAG_W-1:0]   s_event_tag,
    input  wire logic [TIME_W-1:0]  s_now_time,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_fired,
    output logic [TAG_W-1:0]        m_fired_tag,
    output logic                    m_push_dropped
);

    localparam int CntW = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // Control state
    state_t              state_reg, state_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic                m_valid_reg, m_valid_next;

    // Held word: command, computed deadline, tag, tick time
    cmd_t                cmd_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [TIME_W-1:0]   now_reg;

    // Result word
    logic                fired_reg, fired_next;
    logic [TAG_W-1:0]    fired_tag_reg, fired_tag_next;
    logic                dropped_reg, dropped_next;

    logic                s_accept;
    logic                exec_go;
    logic                queue_full;
    logic                head_expired;
    logic [TIME_W:0]     deadline_sum;
    logic [TIME_W-1:0]   deadline_sat;
    cell_ctl_t           cell_ctl;

    entry_t              cell_entry [QueueDepth];
    logic                cell_move  [QueueDepth];

    assign s_ready        = (state_reg == ST_IDLE);
    assign s_accept       = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_fired        = fired_reg;
    assign m_fired_tag    = fired_tag_reg;
    assign m_push_dropped = dropped_reg;

    // Saturating deadline from the stored time at acceptance
    assign deadline_sum = {1'b0, time_reg} + {{(TIME_W + 1 - DELAY_W){1'b0}}, s_delay_secs};
    assign deadline_sat = deadline_sum[TIME_W] ? {TIME_W{1'b1}} : deadline_sum[TIME_W-1:0];

    // Advance the chain only once the result register is free
    assign exec_go      = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign queue_full   = (count_reg == CntW'(QueueDepth));
    assign head_expired = (count_reg != '0) && (cell_entry[0].deadline < now_reg);

    always_comb begin
        cell_ctl.op                 = OP_HOLD;
        cell_ctl.new_entry.deadline = deadline_reg;
        cell_ctl.new_entry.tag      = tag_reg;
        if (exec_go) begin
            if (cmd_reg == CMD_PUSH) begin
                if (!queue_full) begin
                    cell_ctl.op = OP_INSERT;
                end
            end else if (head_expired) begin
                cell_ctl.op = OP_POP;
            end
        end
    end

    // The cell chain: slot 0 holds the earliest deadline
    for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
        localparam logic [CntW-1:0] Idx = CntW'(i);
        logic   left_move;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0) begin : g_first
            assign left_move  = 1'b0;
            assign left_entry = cell_ctl.new_entry;
        end else begin : g_inner
            assign left_move  = cell_move[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == QueueDepth - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        deq_cell u_cell (
            .aclk        (aclk),
            .ctl         (cell_ctl),
            .occupied    (Idx < count_reg),
            .at_tail     (Idx == count_reg),
            .left_move   (left_move),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .move        (cell_move[i])
        );
    end

    // Sequencer, fill count, stored time and result word
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        time_next      = time_reg;
        m_valid_next   = m_valid_reg;
        fired_next     = fired_reg;
        fired_tag_next = fired_tag_reg;
        dropped_next   = dropped_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next     = ST_IDLE;
                    m_valid_next   = 1'b1;
                    fired_next     = 1'b0;
                    fired_tag_next = '0;
                    dropped_next   = 1'b0;
                    if (cmd_reg == CMD_PUSH) begin
                        if (queue_full) begin
                            dropped_next = 1'b1;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        // store the tick time whether or not anything fires
                        time_next = now_reg;
                        if (head_expired) begin
                            fired_next     = 1'b1;
                            fired_tag_next = cell_entry[0].tag;
                            count_next     = count_reg - 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            time_reg    <= time_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg      <= cmd_t'(s_cmd);
            deadline_reg <= deadline_sat;
            tag_reg      <= s_event_tag;
            now_reg      <= s_now_time;
        end
        fired_reg     <= fired_next;
        fired_tag_reg <= fired_tag_next;
        dropped_reg   <= dropped_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(QueueDepth))
        else $error("fill count beyond queue depth");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(fired_reg && dropped_reg))
        else $error("fired and push_dropped both set");

    a_fire_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && cmd_reg == CMD_TICK && head_expired)
        |=> (count_reg == $past(count_reg) - 1'b1) && fired_reg)
        else $error("fired event did not leave the chain");

    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_go && cmd_reg == CMD_PUSH && queue_full)
        |=> dropped_reg && (count_reg == $past(count_reg)))
        else $error("push into full queue not dropped");

endmodule

`default_nettype wire

@@ tb/sv/deadline_event_queue_test.sv @@
`timescale 1ns / 100ps
// deadline_event_queue_test: self-checking bench for the deadline event queue.
// Depends on deq_pkg and deadline_event_queue; a scoreboard class predicts each
// result word; a task and an always block drive both sides with random idling.

module deadline_event_queue_test;
    import deq_pkg::*;

    localparam int                DEPTH      = QUEUE_DEPTH_DEF;
    localparam int                WORD_GOAL  = 1250;
    localparam int                SHOW_LIMIT = 10;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;

    // One result word as the block should present it.
    typedef struct {
        bit             fired;
        bit [TAG_W-1:0] tag;
        bit             dropped;
    } outcome_t;

    // Timer queue scoreboard: keeps its own sorted copy of the pending events and
    // the stored time, and a FIFO of the result words still owed by the block.
    class timer_board;
        entry_t          pending[$];
        bit [TIME_W-1:0] clock_now = '0;
        outcome_t        due[$];
        int              errors = 0;

        // Update the timer state for an accepted input word; queue its result.
        function void note_word(cmd_t cmd, logic [DELAY_W-1:0] delay,
                                logic [TAG_W-1:0] tag, logic [TIME_W-1:0] now);
            outcome_t    res;
            entry_t      item;
            bit [TIME_W:0] sum;
            int          pos;
            res.fired   = 1'b0;
            res.tag     = '0;
            res.dropped = 1'b0;
            if (cmd == CMD_PUSH) begin
                sum           = {1'b0, clock_now} + (TIME_W + 1)'(delay);
                item.deadline = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                item.tag      = tag;
                if (pending.size() >= DEPTH) begin
                    res.dropped = 1'b1;
                end else begin
                    // equal deadlines keep push order: pass only strictly later ones
                    pos = pending.size();
                    while (pos > 0 && pending[pos-1].deadline > item.deadline)
                        pos--;
                    pending.insert(pos, item);
                end
            end else begin
                clock_now = now;
                if (pending.size() > 0 && pending[0].deadline < now) begin
                    res.fired = 1'b1;
                    res.tag   = pending[0].tag;
                    void'(pending.pop_front());
                end
            end
            due.push_back(res);
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("[%0t] %s", $realtime, what);
        endfunction

        // Compare a result word with the oldest one owed.
        function void check_word(logic fired, logic [TAG_W-1:0] tag, logic dropped);
            outcome_t want;
            if (due.size() == 0) begin
                flag($sformatf("unexpected result word: fired=%0b tag=%h dropped=%0b",
                               fired, tag, dropped));
                return;
            end
            want = due.pop_front();
            if (fired !== want.fired || tag !== want.tag || dropped !== want.dropped)
                flag($sformatf({"mismatch: expected fired=%0b tag=%h dropped=%0b,",
                                " got fired=%0b tag=%h dropped=%0b"},
                               want.fired, want.tag, want.dropped, fired, tag, dropped));
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        function int fill_level();
            return pending.size();
        endfunction

        function bit [TIME_W-1:0] time_now();
            return clock_now;
        endfunction

        function bit [TIME_W-1:0] earliest();
            return pending[0].deadline;
        endfunction

        // Saturated events can never fire, so they occupy slots for good.
        function int stuck_count();
            int n;
            n = 0;
            foreach (pending[i])
                if (pending[i].deadline == TIME_MAX)
                    n++;
            return n;
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_cmd;
    logic [DELAY_W-1:0] s_delay_secs;
    logic [TAG_W-1:0]   s_event_tag;
    logic [TIME_W-1:0]  s_now_time;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_fired;
    logic [TAG_W-1:0]   m_fired_tag;
    logic               m_push_dropped;

    timer_board board;
    bit         flow_quiet = 1'b0;   // set: neither side idles
    int         words_sent = 0;

    deadline_event_queue DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_delay_secs   (s_delay_secs),
        .s_event_tag    (s_event_tag),
        .s_now_time     (s_now_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fired        (m_fired),
        .m_fired_tag    (m_fired_tag),
        .m_push_dropped (m_push_dropped)
    );

    // 2 ns clock, first rising edge at 1 ns.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: stall on roughly 28 percent of clock edges, except in the quiet
    // stretch. Change ready on the falling edge so the block sees it settled.
    always @(negedge aclk) begin
        m_ready <= flow_quiet || ($urandom_range(0, 99) >= 28);
    end

    // Sample on the rising edge: a word moves when valid and ready are both high.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_word(m_fired, m_fired_tag, m_push_dropped);
    end

    // Offer one input word and hold it until the block takes it. Drive on the
    // falling edge; an idle gap drops valid first, so valid is never lowered
    // and raised within one time step.
    task automatic send_word(cmd_t cmd, logic [DELAY_W-1:0] delay,
                             logic [TAG_W-1:0] tag, logic [TIME_W-1:0] now);
        int gap;
        @(negedge aclk);
        gap = (!flow_quiet && $urandom_range(0, 99) < 28) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_delay_secs <= delay;
        s_event_tag  <= tag;
        s_now_time   <= now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_word(cmd, delay, tag, now);
        words_sent++;
    endtask

    // Push: the time field is ignored, so fill it with noise.
    task automatic push_event(logic [DELAY_W-1:0] delay, logic [TAG_W-1:0] tag);
        send_word(CMD_PUSH, delay, tag, $urandom());
    endtask

    // Tick: delay and tag are ignored, so fill them with noise.
    task automatic tick_at(logic [TIME_W-1:0] now);
        send_word(CMD_TICK, DELAY_W'($urandom_range(0, 65535)),
                  TAG_W'($urandom_range(0, 65535)), now);
    endtask

    // Mostly short delays so that ticks catch up with deadlines, some long ones.
    function automatic logic [DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return DELAY_W'($urandom_range(0, 20));
            5, 6, 7:       return DELAY_W'($urandom_range(0, 1000));
            default:       return DELAY_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin : stimulus
        int                 phase;
        logic [DELAY_W-1:0] d;

        board        = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_cmd        = CMD_PUSH;
        s_delay_secs = '0;
        s_event_tag  = '0;
        s_now_time   = '0;

        // Hold reset, then release it on a falling edge.
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- Directed part ----
        tick_at(0);                     // tick on an empty queue
        push_event(0, 16'hFFFF);        // deadline equals the current time
        tick_at(0);                     // equal time does not fire
        tick_at(1);                     // strictly later time fires
        // Two pairs of tied deadlines, pushed interleaved.
        push_event(5, 16'h0001);
        push_event(3, 16'h0002);
        push_event(5, 16'h0003);
        push_event(3, 16'h0004);
        // All four have expired: one leaves per tick, ties in push order, then none.
        repeat (5) tick_at(100);
        // Saturate deadlines at the top of the time range; they stay pending.
        tick_at(TIME_MAX);
        push_event(16'hFFFF, 16'hAAAA);
        push_event(0, 16'h5555);
        tick_at(TIME_MAX);
        // Let time run backwards, then past a fresh deadline.
        tick_at(10);
        push_event(16'hFFFF, 16'h0000);
        tick_at(0);
        tick_at(32'h0001_0010);

        // ---- Random part ----
        // Overflow the queue straight away so drops are seen early.
        repeat (DEPTH + 4) push_event(pick_delay(), TAG_W'($urandom_range(0, 65535)));

        while (words_sent < WORD_GOAL) begin
            // Run without idling on either side for a long stretch mid-test.
            flow_quiet = (words_sent >= 500 && words_sent < 750);

            // Pull time back from the top so pushes do not saturate by accident.
            if (board.time_now() > 32'hF000_0000)
                tick_at($urandom_range(0, 1000));

            phase = $urandom_range(0, 9);
            case (phase)
                0, 1, 2: begin
                    // Burst of pushes, often far enough to fill the queue.
                    repeat ($urandom_range(4, 72))
                        push_event(pick_delay(), TAG_W'($urandom_range(0, 65535)));
                end
                3, 4, 5: begin
                    // Drain: mostly tick just at or past the head deadline.
                    repeat ($urandom_range(4, 72)) begin
                        if (board.fill_level() > board.stuck_count() &&
                            $urandom_range(0, 3) != 0)
                            tick_at(board.earliest() + $urandom_range(0, 2));
                        else
                            tick_at(board.time_now() + $urandom_range(0, 8));
                    end
                end
                6: begin
                    // Interleave with wide random fields, including far time jumps.
                    repeat ($urandom_range(8, 40)) begin
                        if ($urandom_range(0, 1) == 0 && board.time_now() <= 32'hFFFE_0000)
                            push_event(DELAY_W'($urandom_range(0, 65535)),
                                       TAG_W'($urandom_range(0, 65535)));
                        else if ($urandom_range(0, 3) == 0)
                            tick_at($urandom());
                        else
                            tick_at(board.time_now() + $urandom_range(0, 300));
                    end
                end
                7: begin
                    // Tied deadlines, then ticks past them; each tick fires at most one event.
                    d = pick_delay();
                    repeat ($urandom_range(2, 6))
                        push_event(d, TAG_W'($urandom_range(0, 65535)));
                    repeat ($urandom_range(2, 8))
                        tick_at(board.time_now() + d + 1);
                end
                8: begin
                    // Step time backwards, then push relative to the earlier time.
                    tick_at($urandom_range(0, board.time_now()));
                    repeat ($urandom_range(1, 6))
                        push_event(pick_delay(), TAG_W'($urandom_range(0, 65535)));
                end
                default: begin
                    // Visit the top of the time range; cap the events that stick.
                    if (board.stuck_count() < 6) begin
                        tick_at(32'hFFFF_0000 | $urandom_range(0, 65535));
                        push_event(DELAY_W'($urandom_range(0, 65535)),
                                   TAG_W'($urandom_range(0, 65535)));
                        tick_at(TIME_MAX);
                        tick_at($urandom_range(0, 4000));
                    end
                end
            endcase
        end

        flow_quiet = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        // Wait for every owed word, then let the clock run on to catch strays.
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial begin : watchdog
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
